// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// ----- rtl/hrpm_pkg.sv -----
`default_nettype none
package hrpm_pkg;

	// Window depth and derived widths
	localparam int WINDOW_MAX = 15;
	localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int IDX_W      = SLOT_W + 1;
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

	// Q2.13 angle constants
	localparam logic signed [17:0] PI_Q         = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q     = 18'sd51472;
	localparam logic signed [17:0] HALF_PI_Q    = 18'sd12868;
	localparam logic signed [17:0] FLIP_LIMIT_Q = 18'sd21299;

	// Input item kinds
	localparam logic KIND_STEP  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Register map, word index
	typedef enum logic [1:0] {
		REG_GAIN     = 2'd0,
		REG_MAX_RATE = 2'd1,
		REG_WIN_LEN  = 2'd2
	} reg_idx_t;

	localparam logic [15:0] GAIN_RST     = 16'd128;
	localparam logic [14:0] MAX_RATE_RST = 15'd8192;
	localparam logic [3:0]  WIN_LEN_RST  = 4'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_FLIP,
		ST_MUL,
		ST_CLAMP,
		ST_PUSH,
		ST_RANK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic wrap;
		logic flip;
		logic mul;
		logic clamp;
		logic push;
		logic rank_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic rank_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ----- rtl/hrpm_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
module hrpm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           kind,
	output logic                in_ready,
	input  wire hrpm_pkg::stat_t stat,
	output hrpm_pkg::cmd_t      cmd
);

	hrpm_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			hrpm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == hrpm_pkg::KIND_CLEAR) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = hrpm_pkg::ST_WRAP;
					end
				end
			end
			hrpm_pkg::ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_d  = hrpm_pkg::ST_FLIP;
			end
			hrpm_pkg::ST_FLIP: begin
				cmd.flip = 1'b1;
				state_d  = hrpm_pkg::ST_MUL;
			end
			hrpm_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = hrpm_pkg::ST_CLAMP;
			end
			hrpm_pkg::ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = hrpm_pkg::ST_PUSH;
			end
			hrpm_pkg::ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = hrpm_pkg::ST_RANK;
			end
			hrpm_pkg::ST_RANK: begin
				cmd.rank_step = 1'b1;
				if (stat.rank_last) begin
					state_d = hrpm_pkg::ST_OUT;
				end
			end
			hrpm_pkg::ST_OUT: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = hrpm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hrpm_pkg::ST_IDLE;
			end
		endcase
	end

	`ASSERT_CLK(a_load_when_free, clk, arst_n, cmd.out_load |-> stat.out_free, "result loaded over a pending beat")
	`ASSERT_CLK(a_accept_starts, clk, arst_n, cmd.load |=> state_q == hrpm_pkg::ST_WRAP, "accepted step did not start")

endmodule
`default_nettype wire

// ----- rtl/hrpm_dp.sv -----
`default_nettype none
`include "assert_macros.svh"
module hrpm_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hrpm_pkg::cmd_t      cmd,
	output hrpm_pkg::stat_t          stat,
	input  wire logic [15:0]         gain,
	input  wire logic [14:0]         max_turn_rate,
	input  wire logic [3:0]          window_length,
	input  wire logic signed [15:0]  target_heading,
	input  wire logic signed [15:0]  present_heading,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [15:0]       turn_rate,
	output logic signed [15:0]       turn_rate_raw,
	output logic signed [15:0]       heading_error
);

	localparam int SLOT_W = hrpm_pkg::SLOT_W;
	localparam int IDX_W  = hrpm_pkg::IDX_W;
	localparam int CNT_W  = hrpm_pkg::CNT_W;
	localparam int WMAX   = hrpm_pkg::WINDOW_MAX;

	logic signed [15:0] tgt_q, cur_q, werr_q, err_q, last_err_q, raw_q;
	logic               last_vld_q;
	logic signed [32:0] prod_q;
	logic signed [15:0] hist_q [WMAX];
	logic [CNT_W-1:0]   fill_q;
	logic [SLOT_W-1:0]  oldest_q, idx_q;
	logic signed [15:0] lo_q, hi_q;
	logic               found_lo_q, found_hi_q, out_valid_q;

	// Wrap the raw difference once into [-pi, pi]
	logic signed [17:0] diff, wrapped;
	always_comb begin
		diff = 18'(tgt_q) - 18'(cur_q);
		if (diff > hrpm_pkg::PI_Q) begin
			wrapped = diff - hrpm_pkg::TWO_PI_Q;
		end else if (diff < -hrpm_pkg::PI_Q) begin
			wrapped = diff + hrpm_pkg::TWO_PI_Q;
		end else begin
			wrapped = diff;
		end
	end

	// Flip correction against the previous error
	logic signed [17:0] e18, p18, ae, ap, s, r, d, ferr;
	logic               opp;
	always_comb begin
		e18 = 18'(werr_q);
		p18 = last_vld_q ? 18'(last_err_q) : e18;
		ae  = (e18 < 0) ? -e18 : e18;
		ap  = (p18 < 0) ? -p18 : p18;
		s   = ae + ap;
		if (s >= hrpm_pkg::TWO_PI_Q) begin
			r = s - hrpm_pkg::TWO_PI_Q;
		end else if (s >= hrpm_pkg::PI_Q) begin
			r = s - hrpm_pkg::PI_Q;
		end else begin
			r = s;
		end
		d    = (r < hrpm_pkg::PI_Q - r) ? r : hrpm_pkg::PI_Q - r;
		opp  = ((e18 < 0) && (p18 > 0)) || ((e18 > 0) && (p18 < 0));
		ferr = e18;
		if ((ae > hrpm_pkg::FLIP_LIMIT_Q) && opp && (d < hrpm_pkg::HALF_PI_Q)) begin
			ferr = (e18 < 0) ? e18 + hrpm_pkg::TWO_PI_Q : e18 - hrpm_pkg::TWO_PI_Q;
		end
	end

	// Floor shift of the gain product and clamp
	logic signed [24:0] shifted, lim;
	logic signed [15:0] clamped;
	always_comb begin
		shifted = prod_q[32:8];
		lim     = 25'(signed'({1'b0, max_turn_rate}));
		if (shifted > lim) begin
			clamped = lim[15:0];
		end else if (shifted < -lim) begin
			clamped = 16'(-lim);
		end else begin
			clamped = shifted[15:0];
		end
	end

	// Window bookkeeping for a push
	logic [CNT_W-1:0]  win_len, drop, fill_new;
	logic [IDX_W-1:0]  old_sum, wr_sum;
	logic [SLOT_W-1:0] oldest_new, wr_slot;
	always_comb begin
		if (window_length == '0) begin
			win_len = CNT_W'(1);
		end else if (32'(window_length) > WMAX) begin
			win_len = CNT_W'(WMAX);
		end else begin
			win_len = CNT_W'(window_length);
		end
		drop = (fill_q >= win_len) ? CNT_W'(fill_q - win_len + CNT_W'(1)) : '0;
		old_sum = IDX_W'(oldest_q) + IDX_W'(drop);
		oldest_new = (old_sum >= IDX_W'(WMAX)) ? SLOT_W'(old_sum - IDX_W'(WMAX))
			: SLOT_W'(old_sum);
		fill_new = fill_q - drop;
		wr_sum   = IDX_W'(oldest_new) + IDX_W'(fill_new);
		wr_slot  = (wr_sum >= IDX_W'(WMAX)) ? SLOT_W'(wr_sum - IDX_W'(WMAX))
			: SLOT_W'(wr_sum);
	end

	// Slots that hold live window entries
	logic [WMAX-1:0]   in_win;
	logic [IDX_W-1:0]  rel;
	always_comb begin
		rel = '0;
		for (int j = 0; j < WMAX; j++) begin
			if (SLOT_W'(j) >= oldest_q) begin
				rel = IDX_W'(j) - IDX_W'(oldest_q);
			end else begin
				rel = IDX_W'(j) + IDX_W'(WMAX) - IDX_W'(oldest_q);
			end
			in_win[j] = rel < IDX_W'(fill_q);
		end
	end

	// Rank the candidate slot against the live entries
	logic signed [15:0] cand;
	logic [CNT_W-1:0]   lt_cnt, eq_cnt, k_lo, k_hi;
	logic [CNT_W:0]     le_cnt;
	logic               hit_lo, hit_hi;
	always_comb begin
		cand   = hist_q[idx_q];
		lt_cnt = '0;
		eq_cnt = '0;
		for (int j = 0; j < WMAX; j++) begin
			if (in_win[j]) begin
				if (hist_q[j] < cand) begin
					lt_cnt = lt_cnt + CNT_W'(1);
				end else if (hist_q[j] == cand) begin
					eq_cnt = eq_cnt + CNT_W'(1);
				end
			end
		end
		le_cnt = (CNT_W+1)'(lt_cnt) + (CNT_W+1)'(eq_cnt);
		k_lo   = CNT_W'(fill_q - CNT_W'(1)) >> 1;
		k_hi   = fill_q >> 1;
		hit_lo = in_win[idx_q] && (lt_cnt <= k_lo) && ((CNT_W+1)'(k_lo) < le_cnt);
		hit_hi = in_win[idx_q] && (lt_cnt <= k_hi) && ((CNT_W+1)'(k_hi) < le_cnt);
	end

	logic signed [16:0] mid_sum;
	assign mid_sum = 17'(lo_q) + 17'(hi_q);

	assign stat.rank_last = (idx_q == SLOT_W'(WMAX - 1));
	assign stat.out_free  = !out_valid_q || out_ready;

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q <= target_heading;
			cur_q <= present_heading;
		end
		if (cmd.wrap) begin
			werr_q <= wrapped[15:0];
		end
		if (cmd.flip) begin
			err_q <= ferr[15:0];
		end
		if (cmd.mul) begin
			prod_q <= signed'({1'b0, gain}) * err_q;
		end
		if (cmd.clamp) begin
			raw_q <= clamped;
		end
		if (cmd.push) begin
			hist_q[wr_slot] <= raw_q;
		end
		if (cmd.rank_step && hit_lo) begin
			lo_q <= cand;
		end
		if (cmd.rank_step && hit_hi) begin
			hi_q <= cand;
		end
		if (cmd.out_load) begin
			turn_rate     <= mid_sum[16:1];
			turn_rate_raw <= raw_q;
			heading_error <= err_q;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q  <= '0;
			last_vld_q  <= 1'b0;
			fill_q      <= '0;
			oldest_q    <= '0;
			idx_q       <= '0;
			found_lo_q  <= 1'b0;
			found_hi_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.flip) begin
				last_err_q <= ferr[15:0];
				last_vld_q <= 1'b1;
			end
			if (cmd.clear) begin
				fill_q   <= '0;
				oldest_q <= '0;
			end else if (cmd.push) begin
				fill_q   <= fill_new + CNT_W'(1);
				oldest_q <= oldest_new;
			end
			// restart the rank sweep on each push
			if (cmd.push) begin
				idx_q      <= '0;
				found_lo_q <= 1'b0;
				found_hi_q <= 1'b0;
			end else if (cmd.rank_step) begin
				idx_q      <= stat.rank_last ? '0 : idx_q + SLOT_W'(1);
				found_lo_q <= found_lo_q | hit_lo;
				found_hi_q <= found_hi_q | hit_hi;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_fill_bound, clk, arst_n, 32'(fill_q) <= WMAX, "fill count past window depth")
	`ASSERT_CLK(a_push_fills, clk, arst_n, cmd.push |=> fill_q != '0, "window empty after push")
	`ASSERT_CLK(a_median_found, clk, arst_n, cmd.out_load |-> (found_lo_q && found_hi_q), "median ranks not found")
	`ASSERT_NEVER(a_oldest_range, clk, arst_n, 32'(oldest_q) >= WMAX, "oldest slot out of range")

endmodule
`default_nettype wire

// ----- rtl/heading_rate_p_control_median.sv -----
// An accepted step beat is wrapped, flip-corrected, scaled by the gain, clamped, pushed
//   into the window and ranked against every window slot; a clear beat gives no result.
//   A new beat is taken only once the last result is loaded, which waits on out_ready.
// Reset (arst_n low): gain 128, max_turn_rate 8192, window_length 5, window empty,
//   no previous error; history holds no data and needs no clearing pass.
`default_nettype none
module heading_rate_p_control_median (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic signed [15:0] target_heading,
	input  wire logic signed [15:0] present_heading,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      turn_rate,
	output logic signed [15:0]      turn_rate_raw,
	output logic signed [15:0]      heading_error
);

	logic [15:0] gain_q;
	logic [14:0] max_rate_q;
	logic [3:0]  win_len_q;
	logic        wr_en;
	hrpm_pkg::reg_idx_t reg_idx;

	hrpm_pkg::cmd_t  cmd;
	hrpm_pkg::stat_t stat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = hrpm_pkg::reg_idx_t'(paddr[3:2]);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= hrpm_pkg::GAIN_RST;
			max_rate_q <= hrpm_pkg::MAX_RATE_RST;
			win_len_q  <= hrpm_pkg::WIN_LEN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				hrpm_pkg::REG_GAIN:     gain_q     <= pwdata[15:0];
				hrpm_pkg::REG_MAX_RATE: max_rate_q <= pwdata[14:0];
				hrpm_pkg::REG_WIN_LEN:  win_len_q  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (reg_idx)
			hrpm_pkg::REG_GAIN:     prdata = {16'd0, gain_q};
			hrpm_pkg::REG_MAX_RATE: prdata = {17'd0, max_rate_q};
			hrpm_pkg::REG_WIN_LEN:  prdata = {28'd0, win_len_q};
			default:                prdata = '0;
		endcase
	end

	hrpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hrpm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.gain            (gain_q),
		.max_turn_rate   (max_rate_q),
		.window_length   (win_len_q),
		.target_heading  (target_heading),
		.present_heading (present_heading),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.turn_rate       (turn_rate),
		.turn_rate_raw   (turn_rate_raw),
		.heading_error   (heading_error)
	);

endmodule
`default_nettype wire

// ----- sim/heading_rate_p_control_median_tb.sv -----
`timescale 1ns / 100ps

module heading_rate_p_control_median_tb;

	localparam int LATENCY    = 21;
	localparam int CYCLE_CAP  = 600000;
	localparam int IDLE_PCT   = 28;
	localparam int HOLD_LEN   = 400;
	localparam int PI_V       = 25736;
	localparam int TWO_PI_V   = 51472;
	localparam int HALF_PI_V  = 12868;
	localparam int FLIP_LIM_V = 21299;

	typedef struct {
		logic               kind;
		logic signed [15:0] target;
		logic signed [15:0] present;
	} heading_beat_t;

	typedef struct {
		logic signed [15:0] turn;
		logic signed [15:0] raw;
		logic signed [15:0] err;
	} turn_cmd_t;

	// DUT signals
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               kind = hrpm_pkg::KIND_STEP;
	logic signed [15:0] target_heading = '0;
	logic signed [15:0] present_heading = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] turn_rate;
	logic signed [15:0] turn_rate_raw;
	logic signed [15:0] heading_error;

	heading_rate_p_control_median uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.target_heading(target_heading), .present_heading(present_heading),
		.out_valid(out_valid), .out_ready(out_ready),
		.turn_rate(turn_rate), .turn_rate_raw(turn_rate_raw),
		.heading_error(heading_error)
	);

	// Shadow copy of the controller
	logic [15:0] gain_q = hrpm_pkg::GAIN_RST;
	logic [14:0] rate_cap_q = hrpm_pkg::MAX_RATE_RST;
	logic [3:0]  win_len_q = hrpm_pkg::WIN_LEN_RST;
	int          prev_err = 0;
	bit          prev_err_ok = 1'b0;
	int          window_vals [hrpm_pkg::WINDOW_MAX];
	int          window_fill = 0;
	int          window_head = 0;

	heading_beat_t pending_beats[$];
	turn_cmd_t     expected_turns[$];
	heading_beat_t next_beat;

	bit in_taken = 1'b0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int errors = 0;
	int steps_checked = 0;
	int clears_sent = 0;
	int flips_seen = 0;
	int settings_used = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Predict the outputs for one accepted beat
	task automatic predict_turn(input heading_beat_t b);
		int        e, prev, r, d, lim, len, drop, n, s, key, j;
		longint    prod;
		int        sorted [hrpm_pkg::WINDOW_MAX];
		turn_cmd_t res;
		if (b.kind == hrpm_pkg::KIND_CLEAR) begin
			window_fill = 0;
			window_head = 0;
			clears_sent++;
		end else begin
			e = int'($signed(b.target)) - int'($signed(b.present));
			if (e > PI_V)
				e -= TWO_PI_V;
			else if (e < -PI_V)
				e += TWO_PI_V;
			prev = prev_err_ok ? prev_err : e;
			// flip correction: large error whose sign turned against the last one
			if ((e > FLIP_LIM_V || e < -FLIP_LIM_V) &&
			    ((e < 0 && prev > 0) || (e > 0 && prev < 0))) begin
				r = ((e < 0 ? -e : e) + (prev < 0 ? -prev : prev)) % PI_V;
				d = (r < PI_V - r) ? r : PI_V - r;
				if (d < HALF_PI_V) begin
					e = (e < 0) ? e + TWO_PI_V : e - TWO_PI_V;
					flips_seen++;
				end
			end
			prev_err = e;
			prev_err_ok = 1'b1;
			// gain, floor shift, clamp
			prod = longint'(gain_q) * longint'(e);
			prod = prod >>> 8;
			lim = int'(rate_cap_q);
			if (prod > lim)
				prod = lim;
			if (prod < -lim)
				prod = -lim;
			res.raw = prod[15:0];
			// push into the window, dropping the oldest values when full
			len = (win_len_q == 0) ? 1 : int'(win_len_q);
			if (len > hrpm_pkg::WINDOW_MAX)
				len = hrpm_pkg::WINDOW_MAX;
			if (window_fill >= len) begin
				drop = window_fill - len + 1;
				window_head = (window_head + drop) % hrpm_pkg::WINDOW_MAX;
				window_fill -= drop;
			end
			window_vals[(window_head + window_fill) % hrpm_pkg::WINDOW_MAX] = int'(prod);
			window_fill++;
			// median by insertion sort
			n = window_fill;
			for (int i = 0; i < n; i++)
				sorted[i] = window_vals[(window_head + i) % hrpm_pkg::WINDOW_MAX];
			for (int i = 1; i < n; i++) begin
				key = sorted[i];
				j = i;
				while (j > 0 && sorted[j - 1] > key) begin
					sorted[j] = sorted[j - 1];
					j--;
				end
				sorted[j] = key;
			end
			if (n % 2 == 0) begin
				s = sorted[n / 2 - 1] + sorted[n / 2];
				s = s >>> 1;
			end else begin
				s = sorted[n / 2];
			end
			res.turn = s[15:0];
			res.err = e[15:0];
			expected_turns.insert(expected_turns.size(), res);
		end
	endtask

	// Cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Check result beats, then predict accepted input beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_turns.size() == 0) begin
					$display("%0t: unexpected result beat turn=%0d raw=%0d err=%0d",
						$time, turn_rate, turn_rate_raw, heading_error);
					errors++;
				end else begin
					if (turn_rate !== expected_turns[0].turn) begin
						$display("%0t: turn_rate expected %0d actual %0d",
							$time, expected_turns[0].turn, turn_rate);
						errors++;
					end
					if (turn_rate_raw !== expected_turns[0].raw) begin
						$display("%0t: turn_rate_raw expected %0d actual %0d",
							$time, expected_turns[0].raw, turn_rate_raw);
						errors++;
					end
					if (heading_error !== expected_turns[0].err) begin
						$display("%0t: heading_error expected %0d actual %0d",
							$time, expected_turns[0].err, heading_error);
						errors++;
					end
					expected_turns.delete(0);
					steps_checked++;
				end
			end
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				next_beat.kind = kind;
				next_beat.target = target_heading;
				next_beat.present = present_heading;
				predict_turn(next_beat);
			end
		end
	end

	// Drive input beats from the pending queue
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (arst_n && pending_beats.size() > 0 &&
			    (calm || $urandom_range(99) >= IDLE_PCT)) begin
				kind <= pending_beats[0].kind;
				target_heading <= pending_beats[0].target;
				present_heading <= pending_beats[0].present;
				pending_beats.delete(0);
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Accept result beats; hold off once for a long stretch on request
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic queue_beat(input logic k, input int t, input int p);
		heading_beat_t b;
		b.kind = k;
		b.target = t[15:0];
		b.present = p[15:0];
		pending_beats.insert(pending_beats.size(), b);
	endtask

	// Random beat: mostly control steps, a few clears
	task automatic push_random_beat();
		int p, e, t, pick;
		p = int'($urandom_range(TWO_PI_V)) - PI_V;
		pick = $urandom_range(99);
		if (pick < 4) begin
			queue_beat(hrpm_pkg::KIND_CLEAR, int'($urandom_range(TWO_PI_V)) - PI_V, p);
		end else if (pick < 38) begin
			queue_beat(hrpm_pkg::KIND_STEP, int'($urandom_range(TWO_PI_V)) - PI_V, p);
		end else if (pick < 90) begin
			// error near +/- pi, or small error around the present heading
			if (pick < 72)
				e = int'($urandom_range(PI_V, 20000));
			else
				e = int'($urandom_range(800)) - 400;
			if ($urandom_range(1))
				e = -e;
			t = p + e;
			if (t > PI_V)
				t -= TWO_PI_V;
			else if (t < -PI_V)
				t += TWO_PI_V;
			queue_beat(hrpm_pkg::KIND_STEP, t, p);
		end else begin
			queue_beat(hrpm_pkg::KIND_STEP, int'($urandom_range(65535)),
				int'($urandom_range(65535)));
		end
	endtask

	// Wait until the block is drained, then let it finish any clear
	task automatic settle();
		while (pending_beats.size() > 0 || in_valid || expected_turns.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// APB write, then read back through the same port
	task automatic cfg_set(input hrpm_pkg::reg_idx_t idx, input logic [31:0] val,
	                       input logic [31:0] mask);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			hrpm_pkg::REG_GAIN:     gain_q = val[15:0];
			hrpm_pkg::REG_MAX_RATE: rate_cap_q = val[14:0];
			hrpm_pkg::REG_WIN_LEN:  win_len_q = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if ((prdata & mask) !== (val & mask)) begin
			$display("%0t: register %s read expected %0d actual %0d",
				$time, idx.name(), val & mask, prdata & mask);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drain, program a setting, then queue random beats
	task automatic run_phase(input logic [15:0] g, input logic [14:0] m, input logic [3:0] w,
	                         input int n, input bit no_idle, input bit long_hold);
		settle();
		calm = no_idle;
		hold_req = long_hold;
		cfg_set(hrpm_pkg::REG_GAIN, {16'd0, g}, 32'h0000_FFFF);
		cfg_set(hrpm_pkg::REG_MAX_RATE, {17'd0, m}, 32'h0000_7FFF);
		cfg_set(hrpm_pkg::REG_WIN_LEN, {28'd0, w}, 32'h0000_000F);
		settings_used++;
		for (int i = 0; i < n; i++)
			push_random_beat();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed beats at reset settings
		queue_beat(hrpm_pkg::KIND_STEP, 25000, 0);
		queue_beat(hrpm_pkg::KIND_STEP, -25000, 0);
		queue_beat(hrpm_pkg::KIND_STEP, 25736, -25736);
		queue_beat(hrpm_pkg::KIND_STEP, -25736, 25736);
		queue_beat(hrpm_pkg::KIND_STEP, 25736, 0);
		queue_beat(hrpm_pkg::KIND_STEP, -25736, 0);
		queue_beat(hrpm_pkg::KIND_STEP, 32767, -32768);
		queue_beat(hrpm_pkg::KIND_STEP, -32768, 32767);
		queue_beat(hrpm_pkg::KIND_STEP, 0, 0);
		queue_beat(hrpm_pkg::KIND_CLEAR, 0, 0);
		queue_beat(hrpm_pkg::KIND_STEP, 21299, 0);
		queue_beat(hrpm_pkg::KIND_STEP, -21300, 0);
		queue_beat(hrpm_pkg::KIND_STEP, 12868, 0);
		queue_beat(hrpm_pkg::KIND_CLEAR, -32768, 32767);
		queue_beat(hrpm_pkg::KIND_STEP, 100, 200);
		queue_beat(hrpm_pkg::KIND_STEP, -25736, -25736);
		queue_beat(hrpm_pkg::KIND_STEP, 25736, 25736);
		queue_beat(hrpm_pkg::KIND_STEP, 16384, -16384);
		queue_beat(hrpm_pkg::KIND_STEP, -1, 1);
		queue_beat(hrpm_pkg::KIND_STEP, 30000, 0);
		queue_beat(hrpm_pkg::KIND_CLEAR, 1, -1);
		queue_beat(hrpm_pkg::KIND_STEP, 5000, -3000);

		// Random phases over a spread of settings
		run_phase(16'hFFFF, 15'h7FFF, 4'd15, 250, 1'b1, 1'b0);
		run_phase(16'd0, 15'd0, 4'd1, 100, 1'b0, 1'b0);
		run_phase(16'hFFFF, 15'h7FFF, 4'd4, 200, 1'b0, 1'b1);
		run_phase(16'($urandom), 15'($urandom), 4'd3, 200, 1'b0, 1'b0);
		run_phase(16'd256, 15'd16384, 4'd0, 120, 1'b0, 1'b0);
		run_phase(16'($urandom), 15'h7FFF, 4'd14, 250, 1'b0, 1'b0);
		run_phase(16'd512, 15'($urandom), 4'd15, 200, 1'b0, 1'b0);
		run_phase(16'd1, 15'h7FFF, 4'd2, 200, 1'b0, 1'b0);
		for (int k = 0; k < 3; k++)
			run_phase(16'($urandom), 15'($urandom), 4'($urandom_range(15)), 105, 1'b0, 1'b0);
		settle();

		if (expected_turns.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_turns.size());
			errors++;
		end
		$display("Run covered %0d checked steps, %0d clears and %0d flip corrections",
			steps_checked, clears_sent, flips_seen);
		$display("over reset values and %0d register settings, %0d mismatches",
			settings_used, errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hrpm_pkg.sv
rtl/hrpm_ctrl.sv
rtl/hrpm_dp.sv
rtl/heading_rate_p_control_median.sv
sim/heading_rate_p_control_median_tb.sv
